// ===== rtl/tlss_pkg.sv =====
// Package for the tree level-set schedule unit: item structs, sequencer states,
// and the request/response types of the shared arithmetic unit.
// No dependencies.
`default_nettype none

package tlss_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam logic [CNT_W-1:0] LVL_SAT = 7'd63;

    typedef struct packed {
        logic             has_parent;
        logic [IDX_W-1:0] parent;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] level;
        logic [IDX_W-1:0] node;
        logic             level_end;
        logic             run_end;
        logic             bad_input;
    } t_out_item;

    typedef enum logic [3:0] {
        S_LOAD,
        S_ERR,
        S_C1,
        S_C2,
        S_C3,
        S_I1,
        S_I2,
        S_W1,
        S_W2,
        S_W3,
        S_W4,
        S_W5,
        S_E1,
        S_E2,
        S_E3
    } t_state;

    typedef enum logic [1:0] {
        ALU_INC,
        ALU_INC_SAT,
        ALU_DEC,
        ALU_CMP
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [CNT_W-1:0] res;
        logic             gt;
        logic             eq;
        logic             res_zero;
    } t_alu_rsp;

endpackage

`default_nettype wire

// ===== rtl/tlss_alu.sv =====
// Shared arithmetic unit of the tree level-set schedule unit: increment,
// saturating level increment, decrement and compare on counts and levels.
// Depends on tlss_pkg.
`default_nettype none

module tlss_alu import tlss_pkg::*; (
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic [CNT_W-1:0] res;

    always_comb begin
        case (i_req.op)
            ALU_INC: begin
                res = i_req.a + 7'd1;
            end
            ALU_INC_SAT: begin
                // saturate at the top level value
                res = (i_req.a >= LVL_SAT) ? LVL_SAT : i_req.a + 7'd1;
            end
            ALU_DEC: begin
                res = i_req.a - 7'd1;
            end
            ALU_CMP: begin
                res = i_req.a;
            end
            default: begin
                res = i_req.a;
            end
        endcase
    end

    assign o_rsp.res      = res;
    assign o_rsp.gt       = (i_req.a > i_req.b);
    assign o_rsp.eq       = (i_req.a == i_req.b);
    assign o_rsp.res_zero = (res == '0);

endmodule

`default_nettype wire

// ===== rtl/tree_level_set_schedule_unit.sv =====
// Top level of the tree level-set schedule unit: load memories, child-count
// driven level walk and level-ordered emission, all under one sequencer.
// Depends on tlss_pkg and tlss_alu.
`default_nettype none

// Parent entries load one per cycle while busy is low. The entry marked last
// closes the forest and raises busy. A bad forest (parent out of range, or
// more than MAX_NODES entries) gives one error result, strobed once the error
// state has registered it. Otherwise the sequencer counts the children of each
// parent, seeds the ready queue with every childless node, walks the queue to
// give each parent a level above its children until it finds the queue empty,
// then emits the nodes level by level, all through one shared increment,
// decrement and compare unit and memories with one read and one write port.
// Results come one at a time on o_strobe and cannot be held off; busy falls
// as the final result is issued.
module tree_level_set_schedule_unit import tlss_pkg::*; #(
    parameter int MAX_NODES = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  wire t_in_item i_item,
    output logic       o_strobe,
    output t_out_item  o_result
);

    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_NODES);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_err, n_err;
    logic [IDX_W-1:0]  r_max_par, n_max_par;
    logic [IDX_W-1:0]  r_max_lvl, n_max_lvl;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_tail, n_tail;
    logic [IDX_W-1:0]  r_p, n_p;
    logic [IDX_W-1:0]  r_cand, n_cand;
    logic [IDX_W-1:0]  r_lv, n_lv;
    logic              r_pend_vld, n_pend_vld;
    logic [IDX_W-1:0]  r_pend_node, n_pend_node;
    logic [STORE_DEPTH-1:0] r_cnt_vld, n_cnt_vld;
    logic [STORE_DEPTH-1:0] r_lvl_vld, n_lvl_vld;
    logic              r_out_vld, n_out_vld;
    t_out_item         r_out, n_out;

    // memories: node entry is {root, parent}
    logic [IDX_W:0]    r_node_mem [STORE_DEPTH];
    logic [CNT_W-1:0]  r_cmem     [STORE_DEPTH];
    logic [IDX_W-1:0]  r_lmem     [STORE_DEPTH];
    logic [IDX_W-1:0]  r_qmem     [STORE_DEPTH];
    logic [IDX_W:0]    r_node_rd;
    logic [CNT_W-1:0]  r_cnt_rd;
    logic [IDX_W-1:0]  r_lvl_rd;
    logic [IDX_W-1:0]  r_q_rd;

    logic              node_we, node_re;
    logic [IDX_W-1:0]  node_waddr, node_raddr;
    logic [IDX_W:0]    node_wdata;
    logic              cnt_we, cnt_re;
    logic [IDX_W-1:0]  cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              lvl_we, lvl_re;
    logic [IDX_W-1:0]  lvl_waddr, lvl_raddr;
    logic [IDX_W-1:0]  lvl_wdata;
    logic              q_we, q_re;
    logic [IDX_W-1:0]  q_waddr, q_raddr;
    logic [IDX_W-1:0]  q_wdata;

    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;

    logic              accept;
    logic              drop;
    logic [CNT_W-1:0]  cnt_after;
    logic [IDX_W-1:0]  max_par_after;
    logic              bad_forest;
    logic              last_i;
    logic              rd_root;
    logic [IDX_W-1:0]  rd_parent;

    tlss_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign busy     = (r_state != S_LOAD);
    assign accept   = start && !busy;
    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    assign drop          = (r_cnt >= MAX_N);
    assign cnt_after     = drop ? r_cnt : r_cnt + 7'd1;
    assign max_par_after = (!drop && i_item.has_parent && (i_item.parent > r_max_par))
                           ? i_item.parent : r_max_par;
    assign bad_forest    = r_err || drop || ({1'b0, max_par_after} >= cnt_after);
    assign last_i        = ({1'b0, r_i} == (r_cnt - 7'd1));
    assign rd_root       = r_node_rd[IDX_W];
    assign rd_parent     = r_node_rd[IDX_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (accept && i_item.last) begin
                    n_state = bad_forest ? S_ERR : S_C1;
                end
            end
            S_ERR: n_state = S_LOAD;
            S_C1:  n_state = S_C2;
            S_C2: begin
                if (!rd_root) begin
                    n_state = S_C3;
                end else begin
                    n_state = last_i ? S_I1 : S_C1;
                end
            end
            S_C3:  n_state = last_i ? S_I1 : S_C1;
            S_I1:  n_state = S_I2;
            S_I2:  n_state = last_i ? S_W1 : S_I1;
            S_W1:  n_state = (r_head == r_tail) ? S_E1 : S_W2;
            S_W2:  n_state = S_W3;
            S_W3:  n_state = rd_root ? S_W1 : S_W4;
            S_W4:  n_state = S_W5;
            S_W5:  n_state = S_W1;
            S_E1:  n_state = S_E2;
            S_E2:  n_state = last_i ? S_E3 : S_E1;
            S_E3:  n_state = (r_lv == r_max_lvl) ? S_LOAD : S_E1;
            default: n_state = S_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_max_par   = r_max_par;
        n_max_lvl   = r_max_lvl;
        n_i         = r_i;
        n_head      = r_head;
        n_tail      = r_tail;
        n_p         = r_p;
        n_cand      = r_cand;
        n_lv        = r_lv;
        n_pend_vld  = r_pend_vld;
        n_pend_node = r_pend_node;
        n_cnt_vld   = r_cnt_vld;
        n_lvl_vld   = r_lvl_vld;
        n_out_vld   = 1'b0;
        n_out       = r_out;

        node_we    = 1'b0;
        node_waddr = r_cnt[IDX_W-1:0];
        node_wdata = {!i_item.has_parent, i_item.has_parent ? i_item.parent : 6'd0};
        node_re    = 1'b0;
        node_raddr = r_i;
        cnt_we     = 1'b0;
        cnt_waddr  = r_p;
        cnt_wdata  = alu_rsp.res;
        cnt_re     = 1'b0;
        cnt_raddr  = r_i;
        lvl_we     = 1'b0;
        lvl_waddr  = r_p;
        lvl_wdata  = r_cand;
        lvl_re     = 1'b0;
        lvl_raddr  = r_i;
        q_we       = 1'b0;
        q_waddr    = r_tail[IDX_W-1:0];
        q_wdata    = r_i;
        q_re       = 1'b0;
        q_raddr    = r_head[IDX_W-1:0];

        alu_req.op = ALU_CMP;
        alu_req.a  = r_cnt_rd;
        alu_req.b  = '0;

        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (drop) begin
                        n_err = 1'b1;
                    end else begin
                        node_we = 1'b1;
                    end
                    n_cnt     = cnt_after;
                    n_max_par = max_par_after;
                    n_i       = '0;
                end
            end
            S_ERR: begin
                n_out_vld       = 1'b1;
                n_out.level     = '0;
                n_out.node      = '0;
                n_out.level_end = 1'b0;
                n_out.run_end   = 1'b1;
                n_out.bad_input = 1'b1;
                n_cnt     = '0;
                n_err     = 1'b0;
                n_max_par = '0;
            end
            S_C1: begin
                node_re = 1'b1;
            end
            S_C2: begin
                if (!rd_root) begin
                    cnt_re    = 1'b1;
                    cnt_raddr = rd_parent;
                    n_p       = rd_parent;
                end else begin
                    n_i = last_i ? '0 : r_i + 6'd1;
                end
            end
            S_C3: begin
                alu_req.op = ALU_INC;
                cnt_we     = 1'b1;
                n_cnt_vld[r_p] = 1'b1;
                n_i        = last_i ? '0 : r_i + 6'd1;
            end
            S_I1: begin
                cnt_re = 1'b1;
            end
            S_I2: begin
                // seed the queue with every node that has no children
                if (alu_rsp.eq) begin
                    q_we   = 1'b1;
                    n_tail = r_tail + 7'd1;
                end
                n_i = r_i + 6'd1;
            end
            S_W1: begin
                if (r_head != r_tail) begin
                    q_re   = 1'b1;
                    n_head = r_head + 7'd1;
                end else begin
                    n_i  = '0;
                    n_lv = '0;
                end
            end
            S_W2: begin
                node_re    = 1'b1;
                node_raddr = r_q_rd;
                lvl_re     = 1'b1;
                lvl_raddr  = r_q_rd;
            end
            S_W3: begin
                alu_req.op = ALU_INC_SAT;
                alu_req.a  = {1'b0, r_lvl_rd};
                n_cand     = alu_rsp.res[IDX_W-1:0];
                n_p        = rd_parent;
                if (!rd_root) begin
                    lvl_re    = 1'b1;
                    lvl_raddr = rd_parent;
                    cnt_re    = 1'b1;
                    cnt_raddr = rd_parent;
                end
            end
            S_W4: begin
                alu_req.a = {1'b0, r_cand};
                alu_req.b = {1'b0, r_lvl_rd};
                if (alu_rsp.gt) begin
                    lvl_we = 1'b1;
                    n_lvl_vld[r_p] = 1'b1;
                    if (r_cand > r_max_lvl) begin
                        n_max_lvl = r_cand;
                    end
                end
            end
            S_W5: begin
                // release the parent once its last child is done
                alu_req.op = ALU_DEC;
                if (r_cnt_rd != '0) begin
                    cnt_we = 1'b1;
                    if (alu_rsp.res_zero) begin
                        q_we    = 1'b1;
                        q_wdata = r_p;
                        n_tail  = r_tail + 7'd1;
                    end
                end
            end
            S_E1: begin
                lvl_re = 1'b1;
            end
            S_E2: begin
                alu_req.a = {1'b0, r_lvl_rd};
                alu_req.b = {1'b0, r_lv};
                if (alu_rsp.eq) begin
                    // hold one node back so the end of level can be marked
                    if (r_pend_vld) begin
                        n_out_vld       = 1'b1;
                        n_out.level     = r_lv;
                        n_out.node      = r_pend_node;
                        n_out.level_end = 1'b0;
                        n_out.run_end   = 1'b0;
                        n_out.bad_input = 1'b0;
                    end
                    n_pend_vld  = 1'b1;
                    n_pend_node = r_i;
                end
                n_i = r_i + 6'd1;
            end
            S_E3: begin
                if (r_pend_vld) begin
                    n_out_vld       = 1'b1;
                    n_out.level     = r_lv;
                    n_out.node      = r_pend_node;
                    n_out.level_end = 1'b1;
                    n_out.run_end   = (r_lv == r_max_lvl);
                    n_out.bad_input = 1'b0;
                end
                n_pend_vld = 1'b0;
                n_i        = '0;
                n_lv       = r_lv + 6'd1;
                if (r_lv == r_max_lvl) begin
                    n_cnt     = '0;
                    n_err     = 1'b0;
                    n_max_par = '0;
                    n_max_lvl = '0;
                    n_head    = '0;
                    n_tail    = '0;
                    n_cnt_vld = '0;
                    n_lvl_vld = '0;
                end
            end
            default: begin
                n_out_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_cnt      <= '0;
            r_err      <= 1'b0;
            r_max_par  <= '0;
            r_max_lvl  <= '0;
            r_i        <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_lv       <= '0;
            r_pend_vld <= 1'b0;
            r_cnt_vld  <= '0;
            r_lvl_vld  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_err      <= n_err;
            r_max_par  <= n_max_par;
            r_max_lvl  <= n_max_lvl;
            r_i        <= n_i;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_lv       <= n_lv;
            r_pend_vld <= n_pend_vld;
            r_cnt_vld  <= n_cnt_vld;
            r_lvl_vld  <= n_lvl_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p         <= n_p;
        r_cand      <= n_cand;
        r_pend_node <= n_pend_node;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            r_node_rd <= r_node_mem[node_raddr];
        end
    end

    // unwritten count and level entries read as zero
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cmem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_rd <= r_cnt_vld[cnt_raddr] ? r_cmem[cnt_raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_lmem[lvl_waddr] <= lvl_wdata;
        end
        if (lvl_re) begin
            r_lvl_rd <= r_lvl_vld[lvl_raddr] ? r_lmem[lvl_raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            r_q_rd <= r_qmem[q_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_tree_level_set_schedule_unit.sv =====
// Testbench for tree_level_set_schedule_unit: loads forests item by item, predicts
// the level-ordered node stream (or the error item) and checks every strobed result.
// Depends on tlss_pkg and the unit's RTL.
`default_nettype none

module tb_tree_level_set_schedule_unit;
    import tlss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 6;
    localparam int MAX_NODES   = 64;
    localparam int ITEM_TARGET = 225;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;
    localparam int REPORT_MAX  = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_item   item_in;
    logic       strobe;
    t_out_item  result;

    // forest being loaded, as the block should hold it
    bit [IDX_W-1:0] ent_parent [STORE_DEPTH];
    bit             ent_root   [STORE_DEPTH];
    int             ent_count;
    bit             ent_overflow;

    t_out_item  sched_q  [$];
    t_in_item   forest_q [$];
    int         items_sent;
    int         fail_count;
    int         cycle_count;
    bit         burst;

    tree_level_set_schedule_unit #(.MAX_NODES(MAX_NODES)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item_in),
        .o_strobe (strobe),
        .o_result (result)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tree_level_set_schedule_unit test failed");
            $finish;
        end
    end

    // Work out levels for the closed forest and queue the node stream.
    function automatic void close_forest();
        int        n;
        int        i;
        int        lv;
        int        nd;
        int        p;
        int        top;
        bit        bad;
        int        kids       [STORE_DEPTH];
        int        lvl        [STORE_DEPTH];
        int        end_of_lvl [STORE_DEPTH];
        int        ready      [$];
        t_out_item r;
        n   = ent_count;
        bad = ent_overflow;
        for (i = 0; i < n; i++)
            if (!ent_root[i] && ent_parent[i] >= n)
                bad = 1'b1;
        if (bad) begin
            r = '0;
            r.run_end   = 1'b1;
            r.bad_input = 1'b1;
            sched_q.insert(sched_q.size(), r);
        end else begin
            for (i = 0; i < STORE_DEPTH; i++) begin
                kids[i]       = 0;
                lvl[i]        = 0;
                end_of_lvl[i] = -1;
            end
            for (i = 0; i < n; i++)
                if (!ent_root[i])
                    kids[ent_parent[i]]++;
            for (i = 0; i < n; i++)
                if (kids[i] == 0)
                    ready.insert(ready.size(), i);
            // leaves first; nodes on a cycle never reach zero children
            while (ready.size() != 0) begin
                nd = ready.pop_front();
                if (ent_root[nd])
                    continue;
                p = ent_parent[nd];
                if (lvl[nd] + 1 > lvl[p])
                    lvl[p] = (lvl[nd] + 1 > 63) ? 63 : lvl[nd] + 1;
                if (kids[p] > 0) begin
                    kids[p]--;
                    if (kids[p] == 0)
                        ready.insert(ready.size(), p);
                end
            end
            top = 0;
            for (i = 0; i < n; i++) begin
                end_of_lvl[lvl[i]] = i;
                if (lvl[i] > top)
                    top = lvl[i];
            end
            for (lv = 0; lv <= top; lv++) begin
                for (i = 0; i < n; i++) begin
                    if (lvl[i] == lv) begin
                        r.level     = 6'(lv);
                        r.node      = 6'(i);
                        r.level_end = (i == end_of_lvl[lv]);
                        r.run_end   = (lv == top) && (i == end_of_lvl[lv]);
                        r.bad_input = 1'b0;
                        sched_q.insert(sched_q.size(), r);
                    end
                end
            end
        end
        ent_count    = 0;
        ent_overflow = 1'b0;
    endfunction

    function automatic void record_entry(input t_in_item it);
        if (ent_count >= MAX_NODES) begin
            ent_overflow = 1'b1;
        end else begin
            ent_parent[ent_count] = it.has_parent ? it.parent : '0;
            ent_root[ent_count]   = !it.has_parent;
            ent_count++;
        end
        if (it.last)
            close_forest();
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && strobe) begin
            if (sched_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("[%0t] unexpected result lvl=%0d node=%0d lend=%b rend=%b bad=%b",
                             $time, result.level, result.node, result.level_end,
                             result.run_end, result.bad_input);
            end else begin
                want = sched_q.pop_front();
                if (want.level != result.level || want.node != result.node ||
                    want.level_end != result.level_end ||
                    want.run_end != result.run_end ||
                    want.bad_input != result.bad_input) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("[%0t] mismatch: exp lvl=%0d node=%0d lend=%b rend=%b bad=%b, %s",
                                 $time, want.level, want.node, want.level_end,
                                 want.run_end, want.bad_input, "see next line");
                    if (fail_count <= REPORT_MAX)
                        $display("           got lvl=%0d node=%0d lend=%b rend=%b bad=%b",
                                 result.level, result.node, result.level_end,
                                 result.run_end, result.bad_input);
                end
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start   <= 1'b1;
        item_in <= it;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        record_entry(it);
        items_sent++;
    endtask

    // drop start first so the held item is not taken twice
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (sched_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic void stage(input bit hp, input bit [IDX_W-1:0] par, input bit lst);
        t_in_item it;
        it.has_parent = hp;
        it.parent     = par;
        it.last       = lst;
        forest_q.insert(forest_q.size(), it);
    endfunction

    task automatic send_forest();
        burst = ($urandom_range(0, 3) == 0);
        while (forest_q.size() != 0)
            send_item(forest_q.pop_front());
    endtask

    task automatic test_lone_roots();
        stage(1'b0, 6'd0, 1'b1);
        send_forest();
        // parent field ignored on a root
        stage(1'b0, 6'd63, 1'b1);
        send_forest();
    endtask

    task automatic test_parent_range();
        stage(1'b1, 6'd63, 1'b1);
        send_forest();
        stage(1'b0, 6'd0, 1'b0);
        stage(1'b1, 6'd2, 1'b1);
        send_forest();
        // highest legal parent
        stage(1'b1, 6'd1, 1'b0);
        stage(1'b0, 6'd5, 1'b1);
        send_forest();
    endtask

    task automatic test_small_tree();
        stage(1'b0, 6'd42, 1'b0);
        stage(1'b1, 6'd0, 1'b0);
        stage(1'b1, 6'd0, 1'b0);
        stage(1'b1, 6'd1, 1'b0);
        stage(1'b1, 6'd3, 1'b1);
        send_forest();
    endtask

    task automatic test_cycles();
        stage(1'b1, 6'd1, 1'b0);
        stage(1'b1, 6'd0, 1'b0);
        stage(1'b1, 6'd0, 1'b1);
        send_forest();
        stage(1'b1, 6'd0, 1'b1);
        send_forest();
    endtask

    task automatic test_overflow();
        int n;
        int i;
        n = MAX_NODES + $urandom_range(1, 3);
        for (i = 0; i < n; i++)
            stage(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), i == n - 1);
        send_forest();
    endtask

    // full-size chain reaches the highest level
    task automatic test_deep_chain();
        int  i;
        bit  up;
        up = 1'($urandom_range(0, 1));
        for (i = 0; i < MAX_NODES; i++) begin
            if (up)
                stage(i != MAX_NODES - 1, 6'(i + 1), i == MAX_NODES - 1);
            else
                stage(i != 0, 6'(i - 1), i == MAX_NODES - 1);
        end
        send_forest();
    endtask

    task automatic test_random_forests();
        int  n;
        int  i;
        int  roll;
        bit  noisy;
        bit  up;
        bit  hp;
        bit  [IDX_W-1:0] par;
        while (items_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                n = $urandom_range(1, 8);
            else if (roll < 95)
                n = $urandom_range(9, 24);
            else
                n = $urandom_range(25, MAX_NODES);
            noisy = ($urandom_range(0, 3) == 0);
            up    = 1'($urandom_range(0, 1));
            for (i = 0; i < n; i++) begin
                par = 6'($urandom_range(0, 63));
                if (noisy) begin
                    hp   = 1'($urandom_range(0, 1));
                    roll = $urandom_range(0, 9);
                    if (roll < 5)
                        par = 6'($urandom_range(0, n - 1));
                    else if (roll == 5)
                        par = 6'(n);
                end else if ((up && i == n - 1) || (!up && i == 0) ||
                             $urandom_range(0, 4) == 0) begin
                    hp = 1'b0;
                end else begin
                    hp  = 1'b1;
                    par = up ? 6'($urandom_range(i + 1, n - 1)) : 6'($urandom_range(0, i - 1));
                end
                stage(hp, par, i == n - 1);
            end
            send_forest();
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        item_in      = '0;
        ent_count    = 0;
        ent_overflow = 1'b0;
        items_sent   = 0;
        fail_count   = 0;
        cycle_count  = 0;
        burst        = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_lone_roots();
        test_parent_range();
        test_small_tree();
        test_cycles();
        drain_results();
        test_overflow();
        test_deep_chain();
        test_random_forests();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tree_level_set_schedule_unit test passed");
        else
            $display("tree_level_set_schedule_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
